@@ design/clc_pkg.sv @@
// clc_pkg: shared constants and types for the combination lock controller.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clc_pkg;

    localparam int CODE_DIGITS = 4;
    localparam int DIGIT_W     = 4;
    localparam int SAMPLE_W    = 12;
    localparam int CODE_W      = 16;
    localparam int FAIL_W      = 4;
    localparam int CNT_W       = 3;
    localparam int EVENT_W     = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam int CODE_EXT_W  = (CODE_DIGITS * DIGIT_W > CODE_W) ?
                                 CODE_DIGITS * DIGIT_W : CODE_W;
    localparam int PROD_W      = SAMPLE_W + 4;

    localparam logic [CODE_W-1:0] CODE_RESET = 16'h1111;
    localparam logic [FAIL_W-1:0] MAX_FAIL_RESET = 4'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CODE_WORD    = 1'd0;
    localparam t_cfg_idx CFG_MAX_FAILURES = 1'd1;

    typedef logic [EVENT_W-1:0] t_event;
    localparam t_event EV_NONE    = 3'd0;
    localparam t_event EV_STORED  = 3'd1;
    localparam t_event EV_UNLOCK  = 3'd2;
    localparam t_event EV_WRONG   = 3'd3;
    localparam t_event EV_LOCKOUT = 3'd4;

    typedef logic [DIGIT_W-1:0] t_digit;

endpackage

`default_nettype wire

@@ design/combination_lock_controller_unit.sv @@
// combination_lock_controller_unit: top level of the combination lock controller.
// Depends on clc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one poll (selector sample and button level) per transfer and returns one
// result per poll: the quantized digit, an event code and the digits held. A poll
// can be accepted every cycle while o_in_stall is low; the poll sits in the input
// register until the result register is free, then loads the result register and
// the updated lock state, and its result is offered. Stall on the result side
// backs up into the input register only when both are full.
// Configuration writes take effect at once and are meant for idle periods only.
module combination_lock_controller_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [clc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [clc_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  [clc_pkg::SAMPLE_W-1:0]         i_pot_sample,
    input  wire                                  i_button_level,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [clc_pkg::DIGIT_W-1:0]          o_shown_digit,
    output logic [clc_pkg::EVENT_W-1:0]          o_event_code,
    output logic [clc_pkg::CNT_W-1:0]            o_digits_entered
);

    logic [clc_pkg::CODE_W-1:0]   r_code_word;
    logic [clc_pkg::FAIL_W-1:0]   r_max_fail;

    logic                         r_in_valid;
    logic [clc_pkg::SAMPLE_W-1:0] r_in_sample;
    logic                         r_in_button;

    logic                         r_out_valid;
    clc_pkg::t_digit              r_out_digit;
    clc_pkg::t_event              r_out_event;
    logic [clc_pkg::CNT_W-1:0]    r_out_count;

    logic                         r_prev;
    logic [clc_pkg::CNT_W-1:0]    r_entry_cnt;
    logic [clc_pkg::FAIL_W-1:0]   r_fail_cnt;
    clc_pkg::t_digit              r_digits [clc_pkg::CODE_DIGITS];

    logic                         w_out_free;
    logic                         w_proc;
    logic                         w_in_take;
    logic [clc_pkg::PROD_W-1:0]   w_prod;
    clc_pkg::t_digit              w_digit;
    logic                         w_rise;
    logic                         w_last;
    logic                         w_match;
    logic [clc_pkg::CODE_EXT_W-1:0] w_code_ext;
    logic [clc_pkg::FAIL_W-1:0]   w_fail_inc;

    clc_pkg::t_event              n_event;
    logic [clc_pkg::CNT_W-1:0]    n_entry_cnt;
    logic [clc_pkg::FAIL_W-1:0]   n_fail_cnt;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_proc     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // digit = (sample * 10) >> 12
    assign w_prod  = {1'b0, r_in_sample, 3'b000} + {3'b000, r_in_sample, 1'b0};
    assign w_digit = w_prod[clc_pkg::PROD_W-1 -: clc_pkg::DIGIT_W];

    assign w_rise     = r_in_button && !r_prev;
    assign w_last     = (r_entry_cnt == clc_pkg::CNT_W'(clc_pkg::CODE_DIGITS - 1));
    assign w_code_ext = clc_pkg::CODE_EXT_W'(r_code_word);
    assign w_fail_inc = r_fail_cnt + 1'b1;

    always_comb begin
        w_match = 1'b1;
        for (int i = 0; i < clc_pkg::CODE_DIGITS; i++) begin
            if (i == clc_pkg::CODE_DIGITS - 1) begin
                if (w_digit != w_code_ext[clc_pkg::DIGIT_W*i +: clc_pkg::DIGIT_W]) begin
                    w_match = 1'b0;
                end
            end else if (r_digits[i] !=
                         w_code_ext[clc_pkg::DIGIT_W*i +: clc_pkg::DIGIT_W]) begin
                w_match = 1'b0;
            end
        end
    end

    always_comb begin
        n_event     = clc_pkg::EV_NONE;
        n_entry_cnt = r_entry_cnt;
        n_fail_cnt  = r_fail_cnt;
        if (w_rise) begin
            n_event     = clc_pkg::EV_STORED;
            n_entry_cnt = r_entry_cnt + 1'b1;
            if (w_last) begin
                n_entry_cnt = '0;
                if (w_match) begin
                    n_event    = clc_pkg::EV_UNLOCK;
                    n_fail_cnt = '0;
                end else if (w_fail_inc >= r_max_fail) begin
                    n_event    = clc_pkg::EV_LOCKOUT;
                    n_fail_cnt = '0;
                end else begin
                    n_event    = clc_pkg::EV_WRONG;
                    n_fail_cnt = w_fail_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_word <= clc_pkg::CODE_RESET;
            r_max_fail  <= clc_pkg::MAX_FAIL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                clc_pkg::CFG_CODE_WORD: begin
                    r_code_word <= i_cfg_wdata[clc_pkg::CODE_W-1:0];
                end
                clc_pkg::CFG_MAX_FAILURES: begin
                    r_max_fail <= i_cfg_wdata[clc_pkg::FAIL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= 1'b0;
            r_entry_cnt <= '0;
            r_fail_cnt  <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_proc) begin
                r_prev      <= r_in_button;
                r_entry_cnt <= n_entry_cnt;
                r_fail_cnt  <= n_fail_cnt;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_sample <= i_pot_sample;
            r_in_button <= i_button_level;
        end
        if (w_proc) begin
            r_out_digit <= w_digit;
            r_out_event <= n_event;
            r_out_count <= n_entry_cnt;
            if (w_rise) begin
                r_digits[r_entry_cnt[clc_pkg::IDX_W-1:0]] <= w_digit;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_shown_digit    = r_out_digit;
    assign o_event_code     = r_out_event;
    assign o_digits_entered = r_out_count;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench for combination_lock_controller_unit.
// Drives polls and register writes, predicts each result and checks it on transfer.
// Depends on clc_pkg and combination_lock_controller_unit.
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES = 64;
    localparam int QUIET_LIMIT = 1000;

    typedef logic [clc_pkg::SAMPLE_W-1:0] t_sample;

    typedef struct {
        clc_pkg::t_digit            digit;
        clc_pkg::t_event            ev;
        logic [clc_pkg::CNT_W-1:0]  held;
    } t_lock_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    clc_pkg::t_cfg_idx                  i_cfg_index;
    logic [clc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata;
    logic                               i_in_valid;
    logic                               o_in_stall;
    t_sample                            i_pot_sample;
    logic                               i_button_level;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic [clc_pkg::DIGIT_W-1:0]        o_shown_digit;
    logic [clc_pkg::EVENT_W-1:0]        o_event_code;
    logic [clc_pkg::CNT_W-1:0]          o_digits_entered;

    // lock state as the predictor sees it
    logic [clc_pkg::CODE_W-1:0]         lock_code;
    logic [clc_pkg::FAIL_W-1:0]         fail_limit;
    logic                               prev_btn;
    clc_pkg::t_digit                    stored_digits [8];
    logic [clc_pkg::CNT_W-1:0]          held_cnt;
    logic [clc_pkg::FAIL_W-1:0]         fail_cnt;

    t_lock_result           pending_results [$];
    int                     mismatches = 0;
    int                     quiet_cycles = 0;
    bit                     idle_on = 1'b1;
    bit                     hold_req = 1'b0;

    combination_lock_controller_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pot_sample     (i_pot_sample),
        .i_button_level   (i_button_level),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_shown_digit    (o_shown_digit),
        .o_event_code     (o_event_code),
        .o_digits_entered (o_digits_entered)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_lock_result predict_poll(input t_sample sample, input logic btn);
        t_lock_result                 r;
        logic [clc_pkg::PROD_W-1:0]   prod;
        logic                         match;
        clc_pkg::t_digit              want;
        int                           i;
        prod = {4'b0, sample} * 16'd10;
        r.digit = prod[clc_pkg::PROD_W-1:clc_pkg::PROD_W-clc_pkg::DIGIT_W];
        r.ev = clc_pkg::EV_NONE;
        if (btn && !prev_btn) begin
            stored_digits[held_cnt] = r.digit;
            held_cnt = held_cnt + 1'b1;
            r.ev = clc_pkg::EV_STORED;
            if (held_cnt >= clc_pkg::CODE_DIGITS || held_cnt == 0) begin
                match = 1'b1;
                for (i = 0; i < clc_pkg::CODE_DIGITS && i < 8; i++) begin
                    want = (i < 4) ? lock_code[4*i +: 4] : '0;
                    if (stored_digits[i] != want) match = 1'b0;
                end
                if (match) begin
                    fail_cnt = '0;
                    r.ev = clc_pkg::EV_UNLOCK;
                end else begin
                    fail_cnt = fail_cnt + 1'b1;
                    if (fail_cnt >= fail_limit) begin
                        fail_cnt = '0;
                        r.ev = clc_pkg::EV_LOCKOUT;
                    end else begin
                        r.ev = clc_pkg::EV_WRONG;
                    end
                end
                held_cnt = '0;
            end
        end
        prev_btn = btn;
        r.held = held_cnt;
        return r;
    endfunction

    function automatic t_sample digit_sample(input int d);
        int lo;
        int hi;
        lo = (d * 4096 + 9) / 10;
        hi = ((d + 1) * 4096 + 9) / 10 - 1;
        return t_sample'($urandom_range(hi, lo));
    endfunction

    function automatic t_sample any_sample();
        return t_sample'($urandom_range(4095));
    endfunction

    task automatic send_poll(input t_sample sample, input logic btn);
        int gap;
        if (idle_on && $urandom_range(99) < 17) begin
            gap = int'($urandom_range(4, 1));
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_pot_sample   <= sample;
        i_button_level <= btn;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_poll(sample, btn));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input clc_pkg::t_cfg_idx idx,
                             input logic [clc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (idx == clc_pkg::CFG_CODE_WORD) lock_code = data;
        else fail_limit = data[clc_pkg::FAIL_W-1:0];
    endtask

    task automatic set_lock(input logic [clc_pkg::CODE_W-1:0] code,
                            input logic [clc_pkg::FAIL_W-1:0] limit);
        wait_drain();
        write_reg(clc_pkg::CFG_CODE_WORD, code);
        write_reg(clc_pkg::CFG_MAX_FAILURES,
                  {{(clc_pkg::CFG_DATA_W-clc_pkg::FAIL_W){1'b0}}, limit});
        i_cfg_we <= 1'b0;
    endtask

    // one code entry; occasional stray polls and held presses break the pattern
    task automatic enter_attempt(input int pct_right);
        int k;
        int d;
        for (k = 0; k < clc_pkg::CODE_DIGITS; k++) begin
            if ($urandom_range(99) < 15)
                send_poll(any_sample(), 1'($urandom_range(1)));
            if ($urandom_range(99) < pct_right && lock_code[4*k +: 4] <= 9)
                d = int'(lock_code[4*k +: 4]);
            else
                d = int'($urandom_range(9));
            send_poll(digit_sample(d), 1'b1);
            if ($urandom_range(99) < 15)
                send_poll(any_sample(), 1'b1);
            send_poll(any_sample(), 1'b0);
        end
    endtask

    function automatic logic [clc_pkg::CODE_W-1:0] random_code();
        return {4'($urandom_range(9)), 4'($urandom_range(9)),
                4'($urandom_range(9)), 4'($urandom_range(9))};
    endfunction

    task automatic test_directed();
        int k;
        send_poll(12'd0, 1'b0);
        send_poll(12'hFFF, 1'b0);
        // held press stores once
        send_poll(digit_sample(1), 1'b1);
        send_poll(digit_sample(7), 1'b1);
        send_poll(12'd0, 1'b0);
        for (k = 0; k < 3; k++) begin
            send_poll(digit_sample(1), 1'b1);
            send_poll(any_sample(), 1'b0);
        end
        // wrong code at a limit of one locks out
        set_lock(clc_pkg::CODE_RESET, 4'd1);
        for (k = 0; k < 2; k++) begin
            send_poll(12'd0, 1'b1);
            send_poll(12'hFFF, 1'b0);
            send_poll(12'hFFF, 1'b1);
            send_poll(12'd0, 1'b0);
        end
    endtask

    task automatic test_config_sweep();
        logic [clc_pkg::CODE_W-1:0] codes [6];
        logic [clc_pkg::FAIL_W-1:0] limits [6];
        int                         p;
        codes  = '{16'h0000, 16'h9999, 16'hFFFF, 16'h9F05, 16'h2580, random_code()};
        limits = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd4, 4'($urandom_range(15, 1))};
        for (p = 0; p < 6; p++) begin
            set_lock(codes[p], limits[p]);
            repeat (5) enter_attempt(70);
        end
    endtask

    task automatic test_backpressure();
        set_lock(random_code(), 4'd3);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (4) enter_attempt(80);
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        int n;
        idle_on = 1'b0;
        repeat (15) enter_attempt(75);
        idle_on = 1'b1;
        for (n = 0; n < 46; n++) begin
            if (n % 10 == 0) set_lock(random_code(), 4'($urandom_range(15, 1)));
            enter_attempt(75);
        end
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= idle_on && ($urandom_range(99) < 17);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_lock_result exp_r;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer, digit %0d event %0d held %0d", $time,
                         o_shown_digit, o_event_code, o_digits_entered);
                mismatches++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_shown_digit !== exp_r.digit) begin
                    $display("%0t: shown_digit expected %0d actual %0d", $time,
                             exp_r.digit, o_shown_digit);
                    mismatches++;
                end
                if (o_event_code !== exp_r.ev) begin
                    $display("%0t: event_code expected %0d actual %0d", $time,
                             exp_r.ev, o_event_code);
                    mismatches++;
                end
                if (o_digits_entered !== exp_r.held) begin
                    $display("%0t: digits_entered expected %0d actual %0d", $time,
                             exp_r.held, o_digits_entered);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = clc_pkg::CFG_CODE_WORD;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_pot_sample   = '0;
        i_button_level = 1'b0;
        lock_code      = clc_pkg::CODE_RESET;
        fail_limit     = clc_pkg::MAX_FAIL_RESET;
        prev_btn       = 1'b0;
        held_cnt       = '0;
        fail_cnt       = '0;
        foreach (stored_digits[i]) stored_digits[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();
        wait_drain();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
